// ----- sv/v3a_pkg.sv -----
// Shared types, codes and helpers for the three-component vector ALU.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none
package v3a_pkg;

    localparam int DIM        = 3;
    localparam int DATA_W     = 32;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 17;
    localparam int NUM_CELLS  = SQRT_STEPS + DIV_STEPS;

    localparam logic [2:0] CMD_ADD   = 3'd0;
    localparam logic [2:0] CMD_SUB   = 3'd1;
    localparam logic [2:0] CMD_SCALE = 3'd2;
    localparam logic [2:0] CMD_DOT   = 3'd3;
    localparam logic [2:0] CMD_MAG   = 3'd4;
    localparam logic [2:0] CMD_CROSS = 3'd5;
    localparam logic [2:0] CMD_NORM  = 3'd6;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

    // Beat handed from cell to cell
    typedef struct packed {
        logic [2:0]                    cmd;
        logic [DIM-1:0][DATA_W-1:0]    res;
        logic [DATA_W-1:0]             sc;
        logic                          clip;
        logic [63:0]                   rad;
        logic [33:0]                   srem;
        logic [DATA_W-1:0]             root;
        logic [DIM-1:0]                neg;
        logic [DIM-1:0][DATA_W-1:0]    drem;
        logic [DIM-1:0][DIV_STEPS-1:0] dnum;
        logic [DIM-1:0][DIV_STEPS-1:0] quo;
    } t_beat;

    // Truncate a Q32.32 value toward zero to Q16.16 and saturate; msb is the clip flag
    function automatic logic [DATA_W:0] sat_trunc(input logic signed [65:0] v);
        logic signed [65:0] adj;
        logic signed [65:0] q;
        adj = v + (v[65] ? 66'sd65535 : 66'sd0);
        q   = adj >>> 16;
        if (q > 66'sd2147483647) begin
            return {1'b1, Q_MAX};
        end else if (q < -66'sd2147483648) begin
            return {1'b1, Q_MIN};
        end
        return {1'b0, q[DATA_W-1:0]};
    endfunction

    // Saturate a 33-bit sum to 32 bits; msb is the clip flag
    function automatic logic [DATA_W:0] sat33(input logic signed [DATA_W:0] v);
        if (v > 33'sd2147483647) begin
            return {1'b1, Q_MAX};
        end else if (v < -33'sd2147483648) begin
            return {1'b1, Q_MIN};
        end
        return {1'b0, v[DATA_W-1:0]};
    endfunction

endpackage
`default_nettype wire

// ----- sv/v3a_front.sv -----
// Front end: operand select and multipliers, product sums, truncation and saturation.
// Three register stages; depends on v3a_pkg.
`default_nettype none
module v3a_front (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_rst_n,
    input  wire logic [2:0]                                   i_en,
    input  wire logic                                         i_valid,
    input  wire logic [2:0]                                   i_cmd,
    input  wire logic [v3a_pkg::DIM-1:0][v3a_pkg::DATA_W-1:0] i_a,
    input  wire logic [v3a_pkg::DIM-1:0][v3a_pkg::DATA_W-1:0] i_b,
    input  wire logic [v3a_pkg::DATA_W-1:0]                   i_s,
    output logic [2:0]                                        o_valid,
    output v3a_pkg::t_beat                                    o_beat
);
    localparam int NMUL = 2 * v3a_pkg::DIM;

    logic [2:0] r_v;

    // stage 1 registers
    logic [2:0]                                   r1_cmd;
    logic [v3a_pkg::DIM-1:0][v3a_pkg::DATA_W-1:0] r1_a;
    logic [v3a_pkg::DIM-1:0][v3a_pkg::DATA_W-1:0] r1_b;
    logic [NMUL-1:0][63:0]                        r1_p;
    logic [NMUL-1:0][v3a_pkg::DATA_W-1:0]         ma;
    logic [NMUL-1:0][v3a_pkg::DATA_W-1:0]         mb;

    // stage 2 registers
    logic [2:0]                                   r2_cmd;
    logic [v3a_pkg::DIM-1:0][65:0]                r2_w;
    logic [63:0]                                  r2_sq;
    logic [v3a_pkg::DIM-1:0][v3a_pkg::DATA_W-1:0] r2_res;
    logic                                         r2_clip;
    logic [v3a_pkg::DIM-1:0][v3a_pkg::DATA_W-1:0] r2_abs;
    logic [v3a_pkg::DIM-1:0]                      r2_neg;
    logic [v3a_pkg::DIM-1:0][65:0]                n2_w;
    logic [v3a_pkg::DIM-1:0][v3a_pkg::DATA_W-1:0] n2_res;
    logic                                         n2_clip;
    logic [v3a_pkg::DIM-1:0][v3a_pkg::DATA_W-1:0] n2_abs;

    v3a_pkg::t_beat r3_beat;
    v3a_pkg::t_beat n3_beat;

    // Pick multiplier operands for the command
    always_comb begin
        ma = '0;
        mb = '0;
        if (i_cmd == v3a_pkg::CMD_CROSS) begin
            ma[0] = i_a[1]; mb[0] = i_b[2];
            ma[1] = i_a[2]; mb[1] = i_b[1];
            ma[2] = i_a[2]; mb[2] = i_b[0];
            ma[3] = i_a[0]; mb[3] = i_b[2];
            ma[4] = i_a[0]; mb[4] = i_b[1];
            ma[5] = i_a[1]; mb[5] = i_b[0];
        end else begin
            for (int i = 0; i < v3a_pkg::DIM; i++) begin
                ma[i] = i_a[i];
                if (i_cmd == v3a_pkg::CMD_SCALE) begin
                    mb[i] = i_s;
                end else if (i_cmd == v3a_pkg::CMD_MAG || i_cmd == v3a_pkg::CMD_NORM) begin
                    mb[i] = i_a[i];
                end else begin
                    mb[i] = i_b[i];
                end
            end
        end
    end

    // Sums, differences and absolute values
    always_comb begin
        n2_w    = '0;
        n2_res  = '0;
        n2_clip = 1'b0;
        for (int i = 0; i < v3a_pkg::DIM; i++) begin
            logic [v3a_pkg::DATA_W:0] s;
            if (r1_cmd == v3a_pkg::CMD_SUB) begin
                s = v3a_pkg::sat33($signed({r1_a[i][31], r1_a[i]})
                                   - $signed({r1_b[i][31], r1_b[i]}));
            end else begin
                s = v3a_pkg::sat33($signed({r1_a[i][31], r1_a[i]})
                                   + $signed({r1_b[i][31], r1_b[i]}));
            end
            n2_abs[i] = r1_a[i][31] ? (32'd0 - r1_a[i]) : r1_a[i];
            if (r1_cmd == v3a_pkg::CMD_ADD || r1_cmd == v3a_pkg::CMD_SUB) begin
                n2_res[i] = s[31:0];
                n2_clip   = n2_clip | s[32];
            end
        end
        unique case (r1_cmd)
            v3a_pkg::CMD_SCALE: begin
                for (int i = 0; i < v3a_pkg::DIM; i++) begin
                    n2_w[i] = {{2{r1_p[i][63]}}, r1_p[i]};
                end
            end
            v3a_pkg::CMD_DOT: begin
                n2_w[0] = {{2{r1_p[0][63]}}, r1_p[0]} + {{2{r1_p[1][63]}}, r1_p[1]}
                        + {{2{r1_p[2][63]}}, r1_p[2]};
            end
            v3a_pkg::CMD_CROSS: begin
                n2_w[0] = {{2{r1_p[0][63]}}, r1_p[0]} - {{2{r1_p[1][63]}}, r1_p[1]};
                n2_w[1] = {{2{r1_p[2][63]}}, r1_p[2]} - {{2{r1_p[3][63]}}, r1_p[3]};
                n2_w[2] = {{2{r1_p[4][63]}}, r1_p[4]} - {{2{r1_p[5][63]}}, r1_p[5]};
            end
            default: begin
                n2_w = '0;
            end
        endcase
    end

    // Truncate, saturate and seed the square root and divider fields
    always_comb begin
        logic [v3a_pkg::DATA_W:0] t;
        n3_beat      = '0;
        n3_beat.cmd  = r2_cmd;
        n3_beat.neg  = r2_neg;
        n3_beat.res  = r2_res;
        n3_beat.clip = r2_clip;
        t            = '0;
        for (int i = 0; i < v3a_pkg::DIM; i++) begin
            n3_beat.drem[i] = {1'b0, r2_abs[i][31:1]};
            n3_beat.dnum[i] = {r2_abs[i][0], 16'd0};
        end
        unique case (r2_cmd)
            v3a_pkg::CMD_SCALE, v3a_pkg::CMD_CROSS: begin
                for (int i = 0; i < v3a_pkg::DIM; i++) begin
                    t = v3a_pkg::sat_trunc(r2_w[i]);
                    n3_beat.res[i] = t[31:0];
                    n3_beat.clip   = n3_beat.clip | t[32];
                end
            end
            v3a_pkg::CMD_DOT: begin
                t = v3a_pkg::sat_trunc(r2_w[0]);
                n3_beat.sc   = t[31:0];
                n3_beat.clip = t[32];
            end
            v3a_pkg::CMD_MAG, v3a_pkg::CMD_NORM: begin
                n3_beat.rad = r2_sq;
            end
            default: begin
                n3_beat.rad = '0;
            end
        endcase
    end

    // Advance valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (i_en[0]) r_v[0] <= i_valid;
            if (i_en[1]) r_v[1] <= r_v[0];
            if (i_en[2]) r_v[2] <= r_v[1];
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_cmd <= i_cmd;
            r1_a   <= i_a;
            r1_b   <= i_b;
            for (int k = 0; k < NMUL; k++) begin
                r1_p[k] <= $signed({{32{ma[k][31]}}, ma[k]}) * $signed({{32{mb[k][31]}}, mb[k]});
            end
        end
        if (i_en[1]) begin
            r2_cmd  <= r1_cmd;
            r2_w    <= n2_w;
            r2_sq   <= r1_p[0] + r1_p[1] + r1_p[2];
            r2_res  <= n2_res;
            r2_clip <= n2_clip;
            r2_abs  <= n2_abs;
            for (int i = 0; i < v3a_pkg::DIM; i++) begin
                r2_neg[i] <= r1_a[i][31];
            end
        end
        if (i_en[2]) begin
            r3_beat <= n3_beat;
        end
    end

    assign o_valid = r_v;
    assign o_beat  = r3_beat;

endmodule
`default_nettype wire

// ----- sv/v3a_sqrt_cell.sv -----
// One digit step of the integer square root: takes two radicand bits, yields one root bit.
// Depends on v3a_pkg.
`default_nettype none
module v3a_sqrt_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  v3a_pkg::t_beat      i_beat,
    output logic                o_valid,
    output v3a_pkg::t_beat      o_beat
);
    logic           r_v;
    v3a_pkg::t_beat r_beat;
    v3a_pkg::t_beat n_beat;
    logic [35:0]    rem_t;
    logic [35:0]    trial;

    // Compare against the trial root and pass the rest on
    always_comb begin
        n_beat = i_beat;
        rem_t  = {i_beat.srem, i_beat.rad[63:62]};
        trial  = {2'b00, i_beat.root, 2'b01};
        n_beat.rad = {i_beat.rad[61:0], 2'b00};
        if (rem_t >= trial) begin
            n_beat.srem = rem_t[33:0] - trial[33:0];
            n_beat.root = {i_beat.root[30:0], 1'b1};
        end else begin
            n_beat.srem = rem_t[33:0];
            n_beat.root = {i_beat.root[30:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_v;
    assign o_beat  = r_beat;

endmodule
`default_nettype wire

// ----- sv/v3a_div_cell.sv -----
// One restoring division step on all three lanes, dividing by the magnitude.
// Depends on v3a_pkg.
`default_nettype none
module v3a_div_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  v3a_pkg::t_beat      i_beat,
    output logic                o_valid,
    output v3a_pkg::t_beat      o_beat
);
    logic           r_v;
    v3a_pkg::t_beat r_beat;
    v3a_pkg::t_beat n_beat;

    // Shift in one numerator bit per lane and subtract the divisor when it fits
    always_comb begin
        logic [v3a_pkg::DATA_W:0] t;
        logic [v3a_pkg::DATA_W:0] den;
        n_beat = i_beat;
        den    = {1'b0, i_beat.root};
        t      = '0;
        for (int i = 0; i < v3a_pkg::DIM; i++) begin
            t = {i_beat.drem[i], i_beat.dnum[i][v3a_pkg::DIV_STEPS-1]};
            n_beat.dnum[i] = {i_beat.dnum[i][v3a_pkg::DIV_STEPS-2:0], 1'b0};
            if (t >= den) begin
                n_beat.drem[i] = t[31:0] - den[31:0];
                n_beat.quo[i]  = {i_beat.quo[i][v3a_pkg::DIV_STEPS-2:0], 1'b1};
            end else begin
                n_beat.drem[i] = t[31:0];
                n_beat.quo[i]  = {i_beat.quo[i][v3a_pkg::DIV_STEPS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_v;
    assign o_beat  = r_beat;

endmodule
`default_nettype wire

// ----- sv/vector3_alu.sv -----
// Top level of the three-component Q16.16 vector ALU.
// Uses v3a_pkg, v3a_front, v3a_sqrt_cell and v3a_div_cell.
//
// Usage:
//   Input channel: i_valid / o_stall with i_cmd, vectors a and b and
//   i_scale_factor. A beat is taken at a clock edge with i_valid high and
//   o_stall low. Output channel: o_valid / i_stall with o_r_x, o_r_y, o_r_z,
//   o_scalar_out and o_status; one result beat per input beat, in order.
//   Every operation runs through the same pipeline: three front stages
//   (multiply, sum, truncate and saturate), 32 square root cells, 17 divider
//   cells and the output register. Throughput is one beat per cycle while
//   the receiver does not stall: each cell holds one beat and hands it on
//   unless a stall holds it.
//   When the receiver stalls, the output register holds its beat; stages
//   behind it keep advancing into empty slots, so the block keeps taking
//   input until every stage is full, then raises o_stall.
//   Synchronous active-low reset empties the pipeline; no result is pending
//   afterwards. Opcode 7 returns all-zero fields with status ok.
`default_nettype none
module vector3_alu (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [31:0] i_a_x,
    input  wire logic [31:0] i_a_y,
    input  wire logic [31:0] i_a_z,
    input  wire logic [31:0] i_b_x,
    input  wire logic [31:0] i_b_y,
    input  wire logic [31:0] i_b_z,
    input  wire logic [31:0] i_scale_factor,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_r_x,
    output logic [31:0]      o_r_y,
    output logic [31:0]      o_r_z,
    output logic [31:0]      o_scalar_out,
    output logic [1:0]       o_status
);
    localparam int NC   = v3a_pkg::NUM_CELLS;
    localparam int NSTG = NC + 4;

    logic [NSTG-1:0]  v;
    logic [NSTG-1:0]  en;
    logic [2:0]       fv;
    logic [NC:0]      cv;
    v3a_pkg::t_beat   cb [NC+1];

    logic [v3a_pkg::DIM-1:0][31:0] a_vec;
    logic [v3a_pkg::DIM-1:0][31:0] b_vec;

    logic                          r_ov;
    logic [v3a_pkg::DIM-1:0][31:0] r_res;
    logic [31:0]                   r_sc;
    logic [1:0]                    r_st;
    logic [v3a_pkg::DIM-1:0][31:0] n_res;
    logic [31:0]                   n_sc;
    logic [1:0]                    n_st;

    assign a_vec = {i_a_z, i_a_y, i_a_x};
    assign b_vec = {i_b_z, i_b_y, i_b_x};

    // Stage k moves unless it and every stage after it hold a beat and the output is stalled
    assign v = {r_ov, cv[NC:1], fv};
    for (genvar k = 0; k < NSTG; k++) begin : g_en
        assign en[k] = ~((&v[NSTG-1:k]) & i_stall);
    end
    assign o_stall = ~en[0];

    v3a_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en[2:0]),
        .i_valid (i_valid),
        .i_cmd   (i_cmd),
        .i_a     (a_vec),
        .i_b     (b_vec),
        .i_s     (i_scale_factor),
        .o_valid (fv),
        .o_beat  (cb[0])
    );
    assign cv[0] = fv[2];

    for (genvar j = 0; j < v3a_pkg::SQRT_STEPS; j++) begin : g_sqrt
        v3a_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en[j+3]),
            .i_valid (cv[j]),
            .i_beat  (cb[j]),
            .o_valid (cv[j+1]),
            .o_beat  (cb[j+1])
        );
    end

    for (genvar j = v3a_pkg::SQRT_STEPS; j < NC; j++) begin : g_div
        v3a_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en[j+3]),
            .i_valid (cv[j]),
            .i_beat  (cb[j]),
            .o_valid (cv[j+1]),
            .o_beat  (cb[j+1])
        );
    end

    // Finish magnitude and normalize, build status
    always_comb begin
        logic clip;
        logic zero;
        n_res = cb[NC].res;
        n_sc  = cb[NC].sc;
        clip  = cb[NC].clip;
        zero  = 1'b0;
        if (cb[NC].cmd == v3a_pkg::CMD_MAG) begin
            if (cb[NC].root[31]) begin
                n_sc = v3a_pkg::Q_MAX;
                clip = 1'b1;
            end else begin
                n_sc = cb[NC].root;
            end
        end else if (cb[NC].cmd == v3a_pkg::CMD_NORM) begin
            if (cb[NC].root == '0) begin
                zero  = 1'b1;
                n_res = '0;
            end else begin
                for (int i = 0; i < v3a_pkg::DIM; i++) begin
                    n_res[i] = cb[NC].neg[i] ? (32'd0 - {15'd0, cb[NC].quo[i]})
                                             : {15'd0, cb[NC].quo[i]};
                end
            end
        end
        if (zero) begin
            n_st = v3a_pkg::ST_ZERO;
        end else if (clip) begin
            n_st = v3a_pkg::ST_SAT;
        end else begin
            n_st = v3a_pkg::ST_OK;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en[NSTG-1]) begin
            r_ov <= cv[NC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NSTG-1]) begin
            r_res <= n_res;
            r_sc  <= n_sc;
            r_st  <= n_st;
        end
    end

    assign o_valid      = r_ov;
    assign o_r_x        = r_res[0];
    assign o_r_y        = r_res[1];
    assign o_r_z        = r_res[2];
    assign o_scalar_out = r_sc;
    assign o_status     = r_st;

    // Zero-vector normalize clears every field
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == v3a_pkg::ST_ZERO |->
            o_r_x == '0 && o_r_y == '0 && o_r_z == '0 && o_scalar_out == '0)
        else $error("normalize of zero vector left a nonzero field");

    // A scalar result never comes with a vector result
    a_scalar_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_scalar_out != '0 |-> o_r_x == '0 && o_r_y == '0 && o_r_z == '0)
        else $error("scalar and vector result both nonzero");

    // An accepted beat lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> fv[0])
        else $error("accepted beat lost at entry");

    // Status code 3 is never produced
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != 2'd3)
        else $error("undefined status code");

endmodule
`default_nettype wire

// ----- verif/v3a_checker.sv -----
// Scoreboard for vector3_alu: watches both channels, predicts each result beat
// from the accepted input beat and compares field by field. Depends on v3a_pkg.
`timescale 1ns / 1ps
module v3a_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [31:0] i_a_x,
    input  wire logic [31:0] i_a_y,
    input  wire logic [31:0] i_a_z,
    input  wire logic [31:0] i_b_x,
    input  wire logic [31:0] i_b_y,
    input  wire logic [31:0] i_b_z,
    input  wire logic [31:0] i_scale_factor,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [31:0] i_r_x,
    input  wire logic [31:0] i_r_y,
    input  wire logic [31:0] i_r_z,
    input  wire logic [31:0] i_scalar_out,
    input  wire logic [1:0]  i_status,
    output int               o_fail_count,
    output int               o_pending
);
    typedef logic signed [127:0] t_wide;

    typedef struct packed {
        logic [31:0] r_x;
        logic [31:0] r_y;
        logic [31:0] r_z;
        logic [31:0] scalar_out;
        logic [1:0]  status;
    } t_alu_result;

    t_alu_result result_fifo[$];

    function automatic t_wide sext(input logic [31:0] v);
        logic signed [31:0] s;
        s = v;
        return t_wide'(s);
    endfunction

    // Clip to the Q16.16 range, flag the clip
    function automatic logic [31:0] clip_q(input t_wide v, inout logic clip);
        if (v > t_wide'(64'sd2147483647)) begin
            clip = 1'b1;
            return 32'h7FFF_FFFF;
        end else if (v < -t_wide'(64'sd2147483648)) begin
            clip = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] bitv;
        r    = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic t_alu_result compute_result(
        input logic [2:0] cmd, input logic [31:0] ax, ay, az, bx, by, bz, sf);
        t_wide       a[3];
        t_wide       b[3];
        t_wide       s;
        t_wide       acc;
        logic [63:0] sumsq;
        logic [63:0] mag;
        logic        clip;
        t_alu_result res;
        logic [31:0] r[3];
        a[0] = sext(ax); a[1] = sext(ay); a[2] = sext(az);
        b[0] = sext(bx); b[1] = sext(by); b[2] = sext(bz);
        s    = sext(sf);
        clip = 1'b0;
        res  = '0;
        r    = '{default: 32'd0};
        sumsq = 0;
        for (int i = 0; i < 3; i++) sumsq += 64'(a[i] * a[i]);
        mag = int_sqrt(sumsq);
        case (cmd)
            v3a_pkg::CMD_ADD:
                for (int i = 0; i < 3; i++) r[i] = clip_q(a[i] + b[i], clip);
            v3a_pkg::CMD_SUB:
                for (int i = 0; i < 3; i++) r[i] = clip_q(a[i] - b[i], clip);
            v3a_pkg::CMD_SCALE:
                for (int i = 0; i < 3; i++) r[i] = clip_q((a[i] * s) / 65536, clip);
            v3a_pkg::CMD_DOT: begin
                acc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
                res.scalar_out = clip_q(acc / 65536, clip);
            end
            v3a_pkg::CMD_MAG: begin
                if (mag > 64'h7FFF_FFFF) begin
                    clip = 1'b1;
                    res.scalar_out = 32'h7FFF_FFFF;
                end else begin
                    res.scalar_out = mag[31:0];
                end
            end
            v3a_pkg::CMD_CROSS: begin
                r[0] = clip_q((a[1] * b[2] - a[2] * b[1]) / 65536, clip);
                r[1] = clip_q((a[2] * b[0] - a[0] * b[2]) / 65536, clip);
                r[2] = clip_q((a[0] * b[1] - a[1] * b[0]) / 65536, clip);
            end
            v3a_pkg::CMD_NORM: begin
                if (mag == 0) begin
                    res.status = v3a_pkg::ST_ZERO;
                end else begin
                    for (int i = 0; i < 3; i++)
                        r[i] = clip_q((a[i] * 65536) / t_wide'({64'd0, mag}), clip);
                end
            end
            default: ;
        endcase
        if (clip && res.status == v3a_pkg::ST_OK) res.status = v3a_pkg::ST_SAT;
        res.r_x = r[0];
        res.r_y = r[1];
        res.r_z = r[2];
        return res;
    endfunction

    initial o_fail_count = 0;
    initial o_pending = 0;

    // Predict on every input beat, compare on every result beat
    always @(posedge i_clk) begin
        t_alu_result want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall)
                result_fifo.push_back(compute_result(i_cmd, i_a_x, i_a_y, i_a_z,
                    i_b_x, i_b_y, i_b_z, i_scale_factor));
            if (i_out_valid && !i_out_stall) begin
                if (result_fifo.size() == 0) begin
                    $error("result beat with nothing expected");
                    o_fail_count++;
                end else begin
                    want = result_fifo.pop_front();
                    if (want.r_x != i_r_x) begin
                        $error("r_x: expected %h, got %h", want.r_x, i_r_x);
                        o_fail_count++;
                    end
                    if (want.r_y != i_r_y) begin
                        $error("r_y: expected %h, got %h", want.r_y, i_r_y);
                        o_fail_count++;
                    end
                    if (want.r_z != i_r_z) begin
                        $error("r_z: expected %h, got %h", want.r_z, i_r_z);
                        o_fail_count++;
                    end
                    if (want.scalar_out != i_scalar_out) begin
                        $error("scalar_out: expected %h, got %h",
                            want.scalar_out, i_scalar_out);
                        o_fail_count++;
                    end
                    if (want.status != i_status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = result_fifo.size();
    end
endmodule

// ----- verif/testbench.sv -----
// Top of the vector3_alu testbench: clock, reset, stimulus and verdict.
// Depends on v3a_pkg, vector3_alu and v3a_checker.
`timescale 1ns / 1ps
module testbench;
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  cmd;
    logic [31:0] a_x, a_y, a_z, b_x, b_y, b_z, scale_factor;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] r_x, r_y, r_z, scalar_out;
    logic [1:0]  status;
    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          recv_stall_pct;

    vector3_alu dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_cmd(cmd), .i_a_x(a_x), .i_a_y(a_y), .i_a_z(a_z),
        .i_b_x(b_x), .i_b_y(b_y), .i_b_z(b_z), .i_scale_factor(scale_factor),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_r_x(r_x), .o_r_y(r_y), .o_r_z(r_z), .o_scalar_out(scalar_out),
        .o_status(status)
    );

    v3a_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_cmd(cmd), .i_a_x(a_x), .i_a_y(a_y), .i_a_z(a_z),
        .i_b_x(b_x), .i_b_y(b_y), .i_b_z(b_z), .i_scale_factor(scale_factor),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_r_x(r_x), .i_r_y(r_y), .i_r_z(r_z), .i_scalar_out(scalar_out),
        .i_status(status), .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        clk = 1'b1; #5;
        clk = 1'b0; #5;
    end

    // Receiver back-pressure
    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Present one beat, hold it until taken
    task automatic send_beat(input logic [2:0] c,
        input logic [31:0] ax, ay, az, bx, by, bz, sf);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        cmd = c; a_x = ax; a_y = ay; a_z = az;
        b_x = bx; b_y = by; b_z = bz; scale_factor = sf;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // Random component: full range, small magnitudes or corner values
    function automatic logic [31:0] rand_comp();
        int pick;
        pick = $urandom_range(9);
        if (pick < 4) return $urandom();
        if (pick < 8) return 32'($signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000);
        case ($urandom_range(4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0001_0000;
            3: return 32'hFFFF_FFFF;
            default: return 32'd0;
        endcase
    endfunction

    task automatic send_random(input int count);
        logic [2:0]  c;
        logic [31:0] ax, ay, az;
        for (int n = 0; n < count; n++) begin
            c  = ($urandom_range(49) == 0) ? CMD_UNUSED : 3'($urandom_range(6));
            ax = rand_comp(); ay = rand_comp(); az = rand_comp();
            // Zero vectors now and then for normalize
            if (c == v3a_pkg::CMD_NORM && $urandom_range(19) == 0) begin
                ax = 0; ay = 0; az = 0;
            end
            send_beat(c, ax, ay, az, rand_comp(), rand_comp(), rand_comp(), rand_comp());
        end
    endtask

    initial begin
        #2_000_000;
        $display("** vector3_alu: FAILED **");
        $finish;
    end

    initial begin
        rst_n = 1'b0; in_valid = 1'b0; out_stall = 1'b0;
        cmd = v3a_pkg::CMD_ADD; a_x = 0; a_y = 0; a_z = 0;
        b_x = 0; b_y = 0; b_z = 0; scale_factor = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed: every operation, extremes, zero normalize, unused code
        send_beat(v3a_pkg::CMD_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000, 0);
        send_beat(v3a_pkg::CMD_ADD, 32'h0001_8000, 32'hFFFF_FFFF, 0,
                  32'h0000_8000, 1, 0, 0);
        send_beat(v3a_pkg::CMD_SUB, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0003_0000,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 0);
        send_beat(v3a_pkg::CMD_SCALE, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                  0, 0, 0, 32'h8000_0000);
        send_beat(v3a_pkg::CMD_SCALE, 32'h0002_0000, 32'hFFFE_0000, 32'h0000_0001,
                  0, 0, 0, 32'h0000_8000);
        send_beat(v3a_pkg::CMD_DOT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        send_beat(v3a_pkg::CMD_DOT, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_FFFF,
                  32'h0003_0000, 32'hFFFF_0000, 32'h0000_0001, 0);
        send_beat(v3a_pkg::CMD_MAG, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  0, 0, 0, 0);
        send_beat(v3a_pkg::CMD_MAG, 32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 0);
        send_beat(v3a_pkg::CMD_MAG, 0, 0, 0, 0, 0, 0, 0);
        send_beat(v3a_pkg::CMD_CROSS, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0);
        send_beat(v3a_pkg::CMD_CROSS, 32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, 0);
        send_beat(v3a_pkg::CMD_NORM, 0, 0, 0, 32'hFFFF_FFFF, 1, 2, 3);
        send_beat(v3a_pkg::CMD_NORM, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  0, 0, 0, 0);
        send_beat(v3a_pkg::CMD_NORM, 32'h0000_0001, 0, 0, 0, 0, 0, 0);
        send_beat(v3a_pkg::CMD_NORM, 32'hFFFD_0000, 32'h0004_0000, 0, 0, 0, 0, 0);
        send_beat(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Random phases with changing idle mix
        send_idle_pct = 26; recv_stall_pct = 76;
        send_random(400);
        in_valid = 1'b0;
        // Let the pipeline drain completely before going on
        while (pending != 0) @(negedge clk);
        send_idle_pct = 76; recv_stall_pct = 26;
        send_random(375);
        send_idle_pct = 0; recv_stall_pct = 0;
        send_random(375);
        in_valid = 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (60) @(negedge clk);
        if (fail_count == 0) begin
            $display("** vector3_alu: PASSED **");
        end else begin
            $display("** vector3_alu: FAILED **");
        end
        $finish;
    end
endmodule

// ----- vector3_alu.f -----
sv/v3a_pkg.sv
sv/v3a_front.sv
sv/v3a_sqrt_cell.sv
sv/v3a_div_cell.sv
sv/vector3_alu.sv
verif/v3a_checker.sv
verif/testbench.sv
